[rtl/lqm_pkg.sv]
// Shared types, widths and constants of the link quality monitor.
// Used by every rtl/ module but lqm_div, and by the port checker; depends on nothing.
package lqm_pkg;

    // Default Q16 scale of load values and loss rate.
    localparam int LOAD_SCALE_DEF = 65536;

    // Weight of a new sample in the SNR average is 2**-EMA_SHIFT.
    localparam int EMA_SHIFT = 3;

    // Field widths.
    localparam int CMD_W      = 3;
    localparam int SNR_W      = 8;
    localparam int DENS_W     = 8;
    localparam int IN_LOAD_W  = 32;
    localparam int LOAD_W     = 17;
    localparam int CNT_W      = 32;
    localparam int Q_FRAC     = 16;
    localparam int EMA_W      = SNR_W + Q_FRAC;
    localparam int SF_W       = 4;
    localparam int PCT_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Failures times one hundred.
    localparam int NUM_W = CNT_W + PCT_W;

    // Input word layout, lowest bit up: snr_sample, density_value, load_value.
    localparam int IN_DATA_W = 48;
    localparam int OFS_SNR   = 0;
    localparam int OFS_DENS  = OFS_SNR + SNR_W;
    localparam int OFS_LOAD  = OFS_DENS + DENS_W;

    // Output word layout, lowest bit up.
    localparam int OFS_SF     = 0;
    localparam int OFS_REB    = OFS_SF + SF_W;
    localparam int OFS_PCT    = OFS_REB + 1;
    localparam int OFS_FP     = OFS_PCT + PCT_W;
    localparam int OFS_LOW    = OFS_FP + CNT_W;
    localparam int OFS_HIGH   = OFS_LOW + SNR_W;
    localparam int OFS_AVG    = OFS_HIGH + SNR_W;
    localparam int OFS_SENT   = OFS_AVG + EMA_W;
    localparam int OFS_RECV   = OFS_SENT + CNT_W;
    localparam int OFS_FAIL   = OFS_RECV + CNT_W;
    localparam int OUT_USED_W = OFS_FAIL + CNT_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

    // Event commands.
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TX      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RX      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FAIL    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DENSITY = 3'd4;
    localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd5;
    localparam logic [CMD_W-1:0] CMD_STATUS  = 3'd6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DENS_CRIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DENS_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DENS_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SNR_CRIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SNR_POOR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SNR_GOOD  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_HIGH = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_REB  = 3'd7;

    // Threshold values after reset.
    localparam logic [DENS_W-1:0]        DENS_CRIT_RST = 8'd200;
    localparam logic [DENS_W-1:0]        DENS_HIGH_RST = 8'd150;
    localparam logic [DENS_W-1:0]        DENS_LOW_RST  = 8'd50;
    localparam logic signed [SNR_W-1:0]  SNR_CRIT_RST  = -8'sd15;
    localparam logic signed [SNR_W-1:0]  SNR_POOR_RST  = -8'sd10;
    localparam logic signed [SNR_W-1:0]  SNR_GOOD_RST  = 8'sd5;
    localparam logic [LOAD_W-1:0]        LOAD_HIGH_RST = 17'd52429;
    localparam logic [LOAD_W-1:0]        LOAD_REB_RST  = 17'd58982;

    // Statistics values after reset or clear.
    localparam logic signed [SNR_W-1:0] SNR_MIN_RST = 8'sh7F;
    localparam logic signed [SNR_W-1:0] SNR_MAX_RST = 8'sh80;
    localparam logic [CNT_W-1:0]        CNT_MAX     = 32'hFFFF_FFFF;

    // Loss and decision constants.
    localparam logic [PCT_W-1:0] PCT_FULL    = 7'd100;
    localparam logic [PCT_W-1:0] PCT_REB     = 7'd40;
    localparam int               EMA_HALF    = 1 << (Q_FRAC - 1);
    localparam logic [SF_W-1:0]  SF_SLOWEST  = 4'd12;
    localparam logic [SF_W-1:0]  SF_SLOW     = 4'd11;
    localparam logic [SF_W-1:0]  SF_NORMAL   = 4'd10;
    localparam logic [SF_W-1:0]  SF_FAST     = 4'd9;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV_PCT,
        ST_DIV_FP,
        ST_RESULT
    } lqm_state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic update;
        logic loss_clear;
        logic div_start_pct;
        logic div_start_fp;
        logic fp_latch;
        logic result_load;
    } lqm_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic tx_zero;
        logic div_done;
        logic out_free;
    } lqm_status_t;

endpackage

[rtl/link_quality_monitor.sv]
// Link quality monitor: event statistics, loss figures and spreading factor advice.
// Top level; depends on lqm_pkg, lqm_ctrl, lqm_datapath (and lqm_div below it).
//
// Usage:
//  - s_axis carries one link event per word: s_axis_tuser is the command
//    (clear, transmit, receive, transmit failure, density, load, status) and
//    s_axis_tdata the SNR sample, density and load operands.
//  - m_axis returns exactly one word per event: spreading factor, rebalance
//    flag, loss percent, Q16 loss rate and a copy of the SNR and count statistics after it.
//  - cfg_* writes one of eight thresholds; cfg_ready is always high. Write
//    only while no event is in flight.
//  - When transmits are nonzero, an event runs from acceptance through the
//    one-bit-per-cycle divider, which runs once for the percent and once
//    for the rate, to a valid result. With no transmits both divisions are
//    skipped and the loss figures are cleared to zero.
//  - One event is in work at a time; the next is accepted as soon as the
//    previous result sits in the output register, even if m_axis stalls.
//    A stalled result word holds until taken, and the following result waits.
//  - Synchronous active-low reset restores the thresholds to their defaults
//    and clears all statistics; no result is pending after reset.
module link_quality_monitor
    import lqm_pkg::*;
#(
    parameter int LOAD_SCALE = LOAD_SCALE_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Event channel.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // snr_sample[7:0], density_value[15:8], load_value[47:16]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // command[2:0]
    input  logic [CMD_W-1:0]      s_axis_tuser,
    // Result channel.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // spreading_factor[3:0], rebalance[4], loss_percent[11:5],
    // loss_rate_fp[43:12], snr_lowest[51:44], snr_highest[59:52],
    // snr_average[83:60], sent_count[115:84], received_count[147:116],
    // failure_count[179:148], zero fill[183:180]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // Threshold write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    lqm_cmd_t    cmd;
    lqm_status_t status;

    lqm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lqm_datapath #(
        .LOAD_SCALE (LOAD_SCALE)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .in_command (s_axis_tuser),
        .in_snr     (s_axis_tdata[OFS_SNR +: SNR_W]),
        .in_density (s_axis_tdata[OFS_DENS +: DENS_W]),
        .in_load    (s_axis_tdata[OFS_LOAD +: IN_LOAD_W]),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_tdata    (m_axis_tdata)
    );

    // Threshold writes are never held off.
    assign cfg_ready = 1'b1;

endmodule

[rtl/lqm_div.sv]
// Restoring divider, one quotient bit per cycle, for the loss figures.
// Depends on nothing outside this file.
module lqm_div #(
    parameter int  DVD_W  = 56,
    parameter int  DVS_W  = 32,
    localparam int STEP_W = $clog2(DVD_W + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [STEP_W-1:0] steps,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [DVS_W-1:0]  divisor,
    output logic              busy,
    output logic [DVD_W-1:0]  quotient
);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVD_W-1:0]  dq_reg, dq_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [DVS_W:0]    shifted;
    logic [DVS_W:0]    diff;
    logic              fits;

    // One trial subtraction of the divisor from the partial remainder.
    always_comb begin
        shifted  = {rem_reg, dq_reg[DVD_W-1]};
        diff     = shifted - {1'b0, dvs_reg};
        fits     = ~diff[DVS_W];
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = steps;
            rem_next  = '0;
            dq_next   = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next  = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            dq_next   = {dq_reg[DVD_W-2:0], fits};
            cnt_next  = cnt_reg - STEP_W'(1);
            busy_next = (cnt_reg != STEP_W'(1));
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Remainder, dividend/quotient shift register and divisor.
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = dq_reg;

endmodule

[rtl/lqm_ctrl.sv]
// Controller of the link quality monitor: sequences update, divisions and result.
// Depends on lqm_pkg.
module lqm_ctrl
    import lqm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  lqm_status_t status,
    output lqm_cmd_t    cmd
);

    lqm_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.update = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                // Without transmits the loss figures are zero.
                if (status.tx_zero) begin
                    cmd.loss_clear = 1'b1;
                    state_next     = ST_RESULT;
                end else begin
                    cmd.div_start_pct = 1'b1;
                    state_next        = ST_DIV_PCT;
                end
            end
            ST_DIV_PCT: begin
                if (status.div_done) begin
                    cmd.div_start_fp = 1'b1;
                    state_next       = ST_DIV_FP;
                end
            end
            ST_DIV_FP: begin
                if (status.div_done) begin
                    cmd.fp_latch = 1'b1;
                    state_next   = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (status.out_free) begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/lqm_datapath.sv]
// Datapath of the link quality monitor: thresholds, statistics, loss divider,
// spreading factor decision and output register. Depends on lqm_pkg, lqm_div.
module lqm_datapath
    import lqm_pkg::*;
#(
    parameter int LOAD_SCALE = LOAD_SCALE_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lqm_cmd_t                     cmd,
    output lqm_status_t                  status,
    input  logic [CMD_W-1:0]             in_command,
    input  logic signed [SNR_W-1:0]      in_snr,
    input  logic [DENS_W-1:0]            in_density,
    input  logic [IN_LOAD_W-1:0]         in_load,
    input  logic                         cfg_valid,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [OUT_DATA_W-1:0]        m_tdata
);

    localparam int SCALE_W = $clog2(LOAD_SCALE + 1);
    localparam int DVD_W   = NUM_W + SCALE_W;
    localparam int STEP_W  = $clog2(DVD_W + 1);

    // Threshold registers.
    logic [DENS_W-1:0]       dens_crit_reg, dens_high_reg, dens_low_reg;
    logic signed [SNR_W-1:0] snr_crit_reg, snr_poor_reg, snr_good_reg;
    logic [LOAD_W-1:0]       load_high_reg, load_reb_reg;

    // Statistics registers.
    logic [CNT_W-1:0]        tx_reg, tx_next;
    logic [CNT_W-1:0]        rx_reg, rx_next;
    logic [CNT_W-1:0]        fail_reg, fail_next;
    logic signed [SNR_W-1:0] snr_min_reg, snr_min_next;
    logic signed [SNR_W-1:0] snr_max_reg, snr_max_next;
    logic signed [EMA_W-1:0] ema_reg, ema_next;
    logic                    seen_reg, seen_next;
    logic [DENS_W-1:0]       dens_reg, dens_next;
    logic [LOAD_W-1:0]       load_reg, load_next;

    // Loss computation.
    logic [NUM_W-1:0]        num_reg, num_next;
    logic [PCT_W-1:0]        pct_reg;
    logic [CNT_W-1:0]        fp_reg;
    logic                    div_start;
    logic [STEP_W-1:0]       div_steps;
    logic [DVD_W-1:0]        div_dividend;
    logic                    div_busy;
    logic [DVD_W-1:0]        div_quotient;

    // Average and decision.
    logic signed [EMA_W-1:0] snr_fix;
    logic signed [EMA_W:0]   ema_diff;
    logic signed [EMA_W:0]   ema_step;
    logic signed [EMA_W:0]   avg_sum;
    logic signed [SNR_W:0]   avg_round;
    logic                    snr_below_crit, snr_below_poor, snr_above_good;
    logic [SF_W-1:0]         sf;
    logic                    reb;

    // Output register.
    logic                    m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0]   m_data_reg;

    // Threshold writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dens_crit_reg <= DENS_CRIT_RST;
            dens_high_reg <= DENS_HIGH_RST;
            dens_low_reg  <= DENS_LOW_RST;
            snr_crit_reg  <= SNR_CRIT_RST;
            snr_poor_reg  <= SNR_POOR_RST;
            snr_good_reg  <= SNR_GOOD_RST;
            load_high_reg <= LOAD_HIGH_RST;
            load_reb_reg  <= LOAD_REB_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_DENS_CRIT: dens_crit_reg <= cfg_data[DENS_W-1:0];
                REG_DENS_HIGH: dens_high_reg <= cfg_data[DENS_W-1:0];
                REG_DENS_LOW:  dens_low_reg  <= cfg_data[DENS_W-1:0];
                REG_SNR_CRIT:  snr_crit_reg  <= cfg_data[SNR_W-1:0];
                REG_SNR_POOR:  snr_poor_reg  <= cfg_data[SNR_W-1:0];
                REG_SNR_GOOD:  snr_good_reg  <= cfg_data[SNR_W-1:0];
                REG_LOAD_HIGH: load_high_reg <= cfg_data[LOAD_W-1:0];
                REG_LOAD_REB:  load_reb_reg  <= cfg_data[LOAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Average update: the new sample pulls the average by diff / 2**EMA_SHIFT,
    // the arithmetic shift rounding toward minus infinity.
    always_comb begin
        snr_fix  = {in_snr, {Q_FRAC{1'b0}}};
        ema_diff = {snr_fix[EMA_W-1], snr_fix} - {ema_reg[EMA_W-1], ema_reg};
        ema_step = ema_diff >>> EMA_SHIFT;
    end

    // Event decode.
    always_comb begin
        tx_next      = tx_reg;
        rx_next      = rx_reg;
        fail_next    = fail_reg;
        snr_min_next = snr_min_reg;
        snr_max_next = snr_max_reg;
        ema_next     = ema_reg;
        seen_next    = seen_reg;
        dens_next    = dens_reg;
        load_next    = load_reg;
        unique case (in_command)
            CMD_CLEAR: begin
                tx_next      = '0;
                rx_next      = '0;
                fail_next    = '0;
                snr_min_next = SNR_MIN_RST;
                snr_max_next = SNR_MAX_RST;
                ema_next     = '0;
                seen_next    = 1'b0;
                dens_next    = '0;
                load_next    = '0;
            end
            CMD_TX: begin
                tx_next = (tx_reg != CNT_MAX) ? tx_reg + CNT_W'(1) : tx_reg;
            end
            CMD_RX: begin
                rx_next = (rx_reg != CNT_MAX) ? rx_reg + CNT_W'(1) : rx_reg;
                // The first sample seeds the average.
                ema_next = seen_reg ? ema_reg + ema_step[EMA_W-1:0] : snr_fix;
                if (in_snr < snr_min_reg) begin
                    snr_min_next = in_snr;
                end
                if (in_snr > snr_max_reg) begin
                    snr_max_next = in_snr;
                end
                seen_next = 1'b1;
            end
            CMD_FAIL: begin
                fail_next = (fail_reg != CNT_MAX) ? fail_reg + CNT_W'(1) : fail_reg;
            end
            CMD_DENSITY: begin
                dens_next = in_density;
            end
            CMD_LOAD: begin
                load_next = (in_load <= IN_LOAD_W'(LOAD_SCALE)) ?
                            in_load[LOAD_W-1:0] : LOAD_W'(LOAD_SCALE);
            end
            CMD_STATUS: ;
            default: ;
        endcase
    end

    // Statistics registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_reg      <= '0;
            rx_reg      <= '0;
            fail_reg    <= '0;
            snr_min_reg <= SNR_MIN_RST;
            snr_max_reg <= SNR_MAX_RST;
            ema_reg     <= '0;
            seen_reg    <= 1'b0;
            dens_reg    <= '0;
            load_reg    <= '0;
        end else if (cmd.update) begin
            tx_reg      <= tx_next;
            rx_reg      <= rx_next;
            fail_reg    <= fail_next;
            snr_min_reg <= snr_min_next;
            snr_max_reg <= snr_max_next;
            ema_reg     <= ema_next;
            seen_reg    <= seen_next;
            dens_reg    <= dens_next;
            load_reg    <= load_next;
        end
    end

    // Divider operands. The percent pass divides failures * 100, left
    // aligned so that the quotient lands in the low bits; the rate pass
    // divides failures * 100 * scale over the whole width.
    always_comb begin
        num_next  = NUM_W'(fail_reg) * NUM_W'(PCT_FULL);
        div_start = cmd.div_start_pct | cmd.div_start_fp;
        if (cmd.div_start_pct) begin
            div_dividend = {num_next, {SCALE_W{1'b0}}};
            div_steps    = STEP_W'(NUM_W);
        end else begin
            div_dividend = DVD_W'(num_reg) * DVD_W'(LOAD_SCALE);
            div_steps    = STEP_W'(DVD_W);
        end
    end

    lqm_div #(
        .DVD_W (DVD_W),
        .DVS_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .steps    (div_steps),
        .dividend (div_dividend),
        .divisor  (tx_reg),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // Loss results: percent capped at 100, rate saturated to 32 bits.
    always_ff @(posedge aclk) begin
        if (cmd.div_start_pct) begin
            num_reg <= num_next;
        end
        if (cmd.loss_clear) begin
            pct_reg <= '0;
        end else if (cmd.div_start_fp) begin
            pct_reg <= (div_quotient >= DVD_W'(PCT_FULL)) ?
                       PCT_FULL : div_quotient[PCT_W-1:0];
        end
        if (cmd.loss_clear) begin
            fp_reg <= '0;
        end else if (cmd.fp_latch) begin
            fp_reg <= (|div_quotient[DVD_W-1:CNT_W]) ? CNT_MAX : div_quotient[CNT_W-1:0];
        end
    end

    // Rounded average in whole dB; zero before the first sample. The
    // thresholds are sign extended so that the compares stay signed.
    always_comb begin
        avg_sum   = {ema_reg[EMA_W-1], ema_reg} + (EMA_W+1)'(EMA_HALF);
        avg_round = seen_reg ? avg_sum[EMA_W:Q_FRAC] : '0;
        snr_below_crit = avg_round < $signed({snr_crit_reg[SNR_W-1], snr_crit_reg});
        snr_below_poor = avg_round < $signed({snr_poor_reg[SNR_W-1], snr_poor_reg});
        snr_above_good = avg_round > $signed({snr_good_reg[SNR_W-1], snr_good_reg});
    end

    // Spreading factor and rebalance decision.
    always_comb begin
        if (dens_reg > dens_crit_reg || snr_below_crit) begin
            sf = SF_SLOWEST;
        end else if (dens_reg > dens_high_reg || snr_below_poor ||
                     load_reg > load_high_reg) begin
            sf = SF_SLOW;
        end else if (dens_reg < dens_low_reg && snr_above_good) begin
            sf = SF_FAST;
        end else begin
            sf = SF_NORMAL;
        end
        reb = (dens_reg > dens_high_reg) || (load_reg > load_reb_reg) ||
              (pct_reg > PCT_REB);
    end

    // Output register: holds one finished word until it is taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.result_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.result_load) begin
            m_data_reg <= {{(OUT_DATA_W - OUT_USED_W){1'b0}},
                           fail_reg, rx_reg, tx_reg, ema_reg,
                           snr_max_reg, snr_min_reg, fp_reg, pct_reg, reb, sf};
        end
    end

    assign m_tvalid        = m_valid_reg;
    assign m_tdata         = m_data_reg;
    assign status.tx_zero  = (tx_reg == '0);
    assign status.div_done = ~div_busy;
    assign status.out_free = ~m_valid_reg | m_tready;

endmodule

[rtl/lqm_checker.sv]
// Port-level checks of the link quality monitor, bound to the top level.
// Depends on lqm_pkg and link_quality_monitor.
module lqm_checker
    import lqm_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // A stalled result word stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    // A stalled result word does not change.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // One event at a time: after an accepted event the input closes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("event accepted while another is in work");

    // Loss above the rebalance limit always raises the rebalance flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[OFS_PCT +: PCT_W] > PCT_REB)
        |-> m_axis_tdata[OFS_REB])
        else $error("rebalance flag missing for high loss");

    // A saturated loss rate comes with a loss percent at its cap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[OFS_FP +: CNT_W] == CNT_MAX)
        |-> (m_axis_tdata[OFS_PCT +: PCT_W] == PCT_FULL))
        else $error("saturated loss rate with loss percent below cap");

endmodule

bind link_quality_monitor lqm_checker u_lqm_checker (.*);
